// ----- rtl/rbei_pkg.sv -----
// ----------------------------------------------------------------------------
// rbei_pkg: shared types, codes and helpers for the rigid body integrator
// Beat payload structs, command and register codes, saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rbei_pkg;

  localparam logic [2:0] CMD_FORCE   = 3'd0;
  localparam logic [2:0] CMD_TORQUE  = 3'd1;
  localparam logic [2:0] CMD_TICK    = 3'd2;
  localparam logic [2:0] CMD_WALL    = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  localparam logic [2:0] CFG_MASS    = 3'd0;
  localparam logic [2:0] CFG_RADIUS  = 3'd1;
  localparam logic [2:0] CFG_BOUNCE  = 3'd2;
  localparam logic [2:0] CFG_START_X = 3'd3;
  localparam logic [2:0] CFG_START_Y = 3'd4;
  localparam logic [2:0] CFG_START_A = 3'd5;

  localparam int DIV_NUM_W = 36;
  localparam int DIV_DVD_W = DIV_NUM_W + 16;

  typedef struct packed {
    logic        [2:0]  cmd;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] arm_x;
    logic signed [31:0] arm_y;
    logic        [20:0] step_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic signed [31:0] angle_out;
    logic signed [31:0] spin_out;
    logic               impulse_done;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (&v[51:31] || ~|v[51:31]) begin
      r = v[31:0];
    end else if (v[51]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic signed [51:0] sx32(input logic signed [31:0] v);
    return {{20{v[31]}}, v};
  endfunction

  function automatic logic signed [51:0] sx50(input logic signed [49:0] v);
    return {{2{v[49]}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rbei_div.sv -----
// ----------------------------------------------------------------------------
// rbei_div: iterative Q16.16 divider
// Computes sat32((num * 65536) / den) truncated toward zero, one quotient
// bit per cycle; den must be positive.
// ----------------------------------------------------------------------------
`default_nettype none

module rbei_div
  import rbei_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [DIV_NUM_W-1:0] num,
  input  wire logic        [31:0]          den,
  output logic                             done,
  output logic signed [31:0]               quot
);

  logic                 busy;
  logic [5:0]           cnt;
  logic [31:0]          rem;
  logic [DIV_DVD_W-1:0] dvd;
  logic [DIV_DVD_W-1:0] quo;
  logic                 neg;
  logic [31:0]          den_q;

  logic [DIV_NUM_W-1:0] mag;
  logic [32:0]          rem_sh;
  logic                 ge;
  logic [32:0]          rem_diff;

  assign mag      = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
  assign rem_sh   = {rem, dvd[DIV_DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, den_q};
  assign rem_diff = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        dvd   <= {mag, 16'b0};
        quo   <= '0;
        neg   <= num[DIV_NUM_W-1];
        den_q <= den;
      end else if (busy) begin
        rem <= ge ? rem_diff[31:0] : rem_sh[31:0];
        dvd <= {dvd[DIV_DVD_W-2:0], 1'b0};
        quo <= {quo[DIV_DVD_W-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Saturate the magnitude to the signed 32 bit range, then apply the sign.
  always_comb begin
    if (!neg) begin
      quot = (|quo[DIV_DVD_W-1:31]) ? 32'sh7FFF_FFFF : signed'(quo[31:0]);
    end else if (|quo[DIV_DVD_W-1:32] || (quo[31] && |quo[30:0])) begin
      quot = 32'sh8000_0000;
    end else begin
      quot = signed'(-quo[31:0]);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rigid_body_euler_impulse.sv -----
// ----------------------------------------------------------------------------
// rigid_body_euler_impulse: 2D rigid body integrator in Q16.16
// One body with force and torque accumulators, semi-implicit Euler ticks and
// wall restitution impulses, built on one shared multiplier and divider.
// ----------------------------------------------------------------------------
// Usage: each input beat on in_valid/in_ready carries one command (force,
// torque, tick, wall contact or restart) and produces exactly one output
// beat on out_valid/out_ready with the full body state after that command.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce; a write takes effect at once. Force, restart and
// unused commands report straight from idle; a tick runs 16 sequencer steps,
// three of which wait on a division; a wall contact that hits runs 28 steps
// and 5 divisions, one that misses stops at the closing speed check. Each
// division runs on the shared divider, one quotient bit per cycle over 52
// bits, and that divider sets the throughput. One item is in flight at a time.
// Reset (rst, synchronous) clears the body state and the accumulators and
// loads the configuration defaults: unit mass, radius and restitution.
// When the receiver stalls the result holds on out_data and no new item is
// taken until the result beat has been accepted.
`default_nettype none

module rigid_body_euler_impulse
  import rbei_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TORQ = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;
  localparam logic [1:0] ST_WALL = 2'd3;

  // Configuration.
  logic        [30:0] body_mass;
  logic        [30:0] body_radius;
  logic        [16:0] bounce_factor;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_angle;

  // Body state.
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, angle, spin;
  logic signed [31:0] force_acc_x, force_acc_y, torque_acc;
  logic               hit;

  // Sequencer and working registers.
  logic [1:0]         state;
  logic [4:0]         step;
  in_item_t           item;
  logic signed [31:0] inert;
  logic signed [49:0] tmp_w;
  logic signed [31:0] tmp_b;
  logic signed [31:0] tmp_c;

  // Shared multiplier: the floored Q16.16 product is registered in mres.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [49:0] mres;
  logic signed [31:0] mres_sat;

  // Shared divider.
  logic                        div_start;
  logic signed [DIV_NUM_W-1:0] div_num;
  logic        [31:0]          div_den;
  logic                        div_done;
  logic signed [31:0]          div_q;

  logic        [31:0] mass_val;
  logic signed [31:0] inert_calc;
  logic signed [31:0] inert_half;
  logic signed [51:0] neg_mres;
  logic signed [31:0] close_sum;
  logic               accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE) && !out_valid;

  assign prod     = mul_a * mul_b;
  assign mres_sat = sat32(sx50(mres));
  assign neg_mres = -sx50(mres);

  // Closing speed of the contact point along the wall normal.
  assign close_sum = sat32(sx50(tmp_w) + sx50(mres));

  // A zero mass counts as one LSB, and so does an inertia that rounds to zero.
  assign mass_val   = (body_mass == 31'd0) ? 32'd1 : {1'b0, body_mass};
  assign inert_half = sat32(sx50(mres) >>> 1);
  assign inert_calc = (inert_half[31] || inert_half == 32'sd0) ? 32'sd1 : inert_half;

  rbei_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // Operand selection for the shared units, by sequencer step.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      ST_TORQ: begin
        case (step)
          5'd0: begin mul_a = {item.arm_x[31], item.arm_x}; mul_b = {item.vec_y[31], item.vec_y}; end
          5'd1: begin mul_a = {item.arm_y[31], item.arm_y}; mul_b = {item.vec_x[31], item.vec_x}; end
          default: ;
        endcase
      end
      ST_TICK: begin
        case (step)
          5'd0: begin mul_a = {2'b0, body_radius}; mul_b = {2'b0, body_radius}; end
          5'd1: begin mul_a = {2'b0, body_mass}; mul_b = {mres_sat[31], mres_sat}; end
          5'd2: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(force_acc_x);
            div_den   = mass_val;
          end
          5'd4: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(force_acc_y);
            div_den   = mass_val;
          end
          5'd6: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(torque_acc);
            div_den   = inert;
          end
          5'd8:  begin mul_a = tmp_w[32:0]; mul_b = {12'b0, item.step_time}; end
          5'd9:  begin mul_a = {tmp_b[31], tmp_b}; mul_b = {12'b0, item.step_time}; end
          5'd10: begin mul_a = {vel_x[31], vel_x}; mul_b = {12'b0, item.step_time}; end
          5'd11: begin mul_a = {vel_y[31], vel_y}; mul_b = {12'b0, item.step_time}; end
          5'd12: begin mul_a = {tmp_c[31], tmp_c}; mul_b = {12'b0, item.step_time}; end
          5'd14: begin mul_a = {spin[31], spin}; mul_b = {12'b0, item.step_time}; end
          default: ;
        endcase
      end
      ST_WALL: begin
        case (step)
          5'd0: begin mul_a = {2'b0, body_radius}; mul_b = {2'b0, body_radius}; end
          5'd1: begin mul_a = {2'b0, body_mass}; mul_b = {mres_sat[31], mres_sat}; end
          5'd2: begin mul_a = {spin[31], spin}; mul_b = {item.arm_y[31], item.arm_y}; end
          5'd3: begin mul_a = {spin[31], spin}; mul_b = {item.arm_x[31], item.arm_x}; end
          5'd4: begin mul_a = {tmp_b[31], tmp_b}; mul_b = {item.vec_x[31], item.vec_x}; end
          5'd5: begin mul_a = {tmp_c[31], tmp_c}; mul_b = {item.vec_y[31], item.vec_y}; end
          5'd6: begin mul_a = {item.arm_x[31], item.arm_x}; mul_b = {item.vec_y[31], item.vec_y}; end
          5'd7: begin mul_a = {item.arm_y[31], item.arm_y}; mul_b = {item.vec_x[31], item.vec_x}; end
          5'd9: begin mul_a = {tmp_b[31], tmp_b}; mul_b = {tmp_b[31], tmp_b}; end
          5'd10: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(mres_sat);
            div_den   = inert;
          end
          5'd12: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(36'sd65536);
            div_den   = mass_val;
          end
          5'd14: begin mul_a = {16'b0, bounce_factor} + 33'sd65536; mul_b = {tmp_c[31], tmp_c}; end
          5'd15: begin
            div_start = 1'b1;
            div_num   = neg_mres[DIV_NUM_W-1:0];
            div_den   = tmp_b;
          end
          5'd17: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(tmp_c);
            div_den   = mass_val;
          end
          5'd19: begin mul_a = {item.vec_x[31], item.vec_x}; mul_b = {tmp_b[31], tmp_b}; end
          5'd20: begin mul_a = {item.vec_y[31], item.vec_y}; mul_b = {tmp_b[31], tmp_b}; end
          5'd21: begin mul_a = {item.vec_x[31], item.vec_x}; mul_b = {tmp_c[31], tmp_c}; end
          5'd22: begin mul_a = {item.vec_y[31], item.vec_y}; mul_b = {tmp_c[31], tmp_c}; end
          5'd23: begin mul_a = {item.arm_x[31], item.arm_x}; mul_b = {mres_sat[31], mres_sat}; end
          5'd24: begin mul_a = {item.arm_y[31], item.arm_y}; mul_b = {tmp_b[31], tmp_b}; end
          5'd26: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(tmp_b);
            div_den   = inert;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mres <= prod[65:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      out_valid     <= 1'b0;
      hit           <= 1'b0;
      body_mass     <= 31'd65536;
      body_radius   <= 31'd65536;
      bounce_factor <= 17'd65536;
      start_x       <= '0;
      start_y       <= '0;
      start_angle   <= '0;
      pos_x         <= '0;
      pos_y         <= '0;
      vel_x         <= '0;
      vel_y         <= '0;
      angle         <= '0;
      spin          <= '0;
      force_acc_x   <= '0;
      force_acc_y   <= '0;
      torque_acc    <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_MASS:    body_mass     <= cfg_data[30:0];
          CFG_RADIUS:  body_radius   <= cfg_data[30:0];
          CFG_BOUNCE:  bounce_factor <= cfg_data[16:0];
          CFG_START_X: start_x       <= cfg_data;
          CFG_START_Y: start_y       <= cfg_data;
          CFG_START_A: start_angle   <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            item <= in_data;
            hit  <= 1'b0;
            step <= '0;
            case (in_data.cmd)
              CMD_FORCE: begin
                force_acc_x <= sat32(sx32(force_acc_x) + sx32(in_data.vec_x));
                force_acc_y <= sat32(sx32(force_acc_y) + sx32(in_data.vec_y));
                out_valid   <= 1'b1;
              end
              CMD_TORQUE: state <= ST_TORQ;
              CMD_TICK:   state <= ST_TICK;
              CMD_WALL:   state <= ST_WALL;
              CMD_RESTART: begin
                pos_x       <= start_x;
                pos_y       <= start_y;
                angle       <= start_angle;
                vel_x       <= '0;
                vel_y       <= '0;
                spin        <= '0;
                force_acc_x <= '0;
                force_acc_y <= '0;
                torque_acc  <= '0;
                out_valid   <= 1'b1;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end

        ST_TORQ: begin
          step <= step + 5'd1;
          case (step)
            5'd1: tmp_w <= mres;
            5'd2: begin
              torque_acc <= sat32(sx32(torque_acc) + sx32(sat32(sx50(tmp_w) - sx50(mres))));
              state      <= ST_IDLE;
              out_valid  <= 1'b1;
            end
            default: ;
          endcase
        end

        ST_TICK: begin
          step <= step + 5'd1;
          case (step)
            5'd2: inert <= inert_calc;
            5'd3: if (div_done) tmp_w <= 50'(div_q); else step <= step;
            5'd5: if (div_done) tmp_b <= div_q; else step <= step;
            5'd7: if (div_done) tmp_c <= div_q; else step <= step;
            5'd9:  vel_x <= sat32(sx32(vel_x) + sx50(mres));
            5'd10: vel_y <= sat32(sx32(vel_y) + sx50(mres));
            5'd11: pos_x <= sat32(sx32(pos_x) + sx50(mres));
            5'd12: pos_y <= sat32(sx32(pos_y) + sx50(mres));
            5'd13: spin  <= sat32(sx32(spin) + sx50(mres));
            5'd15: begin
              angle       <= sat32(sx32(angle) + sx50(mres));
              force_acc_x <= '0;
              force_acc_y <= '0;
              torque_acc  <= '0;
              state       <= ST_IDLE;
              out_valid   <= 1'b1;
            end
            default: ;
          endcase
        end

        ST_WALL: begin
          step <= step + 5'd1;
          case (step)
            5'd2: inert <= inert_calc;
            5'd3: tmp_b <= sat32(sx32(vel_x) - sx50(mres));
            5'd4: tmp_c <= sat32(sx32(vel_y) + sx50(mres));
            5'd5: tmp_w <= mres;
            5'd6: begin
              // Closing speed along the normal; a contact that separates or
              // slides along the wall gets no impulse.
              tmp_c <= close_sum;
              if (!close_sum[31]) begin
                state     <= ST_IDLE;
                out_valid <= 1'b1;
              end
            end
            5'd7: tmp_w <= mres;
            5'd8: tmp_b <= sat32(sx50(tmp_w) - sx50(mres));
            5'd11: if (div_done) tmp_b <= div_q; else step <= step;
            5'd13: if (div_done) tmp_b <= sat32(sx32(tmp_b) + sx32(div_q)); else step <= step;
            5'd16: if (div_done) tmp_c <= div_q; else step <= step;
            5'd18: if (div_done) tmp_b <= div_q; else step <= step;
            5'd20: vel_x <= sat32(sx32(vel_x) + sx50(mres));
            5'd21: vel_y <= sat32(sx32(vel_y) + sx50(mres));
            5'd22: tmp_b <= mres_sat;
            5'd24: tmp_w <= mres;
            5'd25: tmp_b <= sat32(sx50(tmp_w) - sx50(mres));
            5'd27: begin
              if (div_done) begin
                spin      <= sat32(sx32(spin) + sx32(div_q));
                hit       <= 1'b1;
                state     <= ST_IDLE;
                out_valid <= 1'b1;
              end else begin
                step <= step;
              end
            end
            default: ;
          endcase
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_data.pos_x_out    = pos_x;
  assign out_data.pos_y_out    = pos_y;
  assign out_data.vel_x_out    = vel_x;
  assign out_data.vel_y_out    = vel_y;
  assign out_data.angle_out    = angle;
  assign out_data.spin_out     = spin;
  assign out_data.impulse_done = hit;

endmodule

`default_nettype wire
